// ===== hdl/rds_pkg.sv =====
// ----------------------------------------------------------------------------
// rds_pkg: shared types, constants and arithmetic helpers
// Q16.16 saturation, product scaling, register indexes and the structs that
// pass between the scan, memory and arithmetic stages.
// ----------------------------------------------------------------------------
package rds_pkg;

  localparam int RDS_PLANE_WIDTH  = 64;
  localparam int RDS_PLANE_HEIGHT = 64;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IW-1:0] REG_INV_DX_SQ   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_INV_DY_SQ   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_INV_DZ_SQ   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_TIME_STEP   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LINEAR_GAIN = 3'd4;
  localparam logic [CFG_IW-1:0] REG_BIAS        = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SLAB_PLANES = 3'd6;

  localparam logic [30:0]        RST_INV_SQ      = 31'd65536;
  localparam logic [30:0]        RST_TIME_STEP   = 31'd6554;
  localparam logic signed [31:0] RST_LINEAR_GAIN = -32'sd65536;
  localparam logic signed [31:0] RST_BIAS        = 32'sd0;
  localparam logic [15:0]        RST_SLAB_PLANES = 16'd32;

  typedef logic [1:0] slot_t;

  typedef struct packed {
    logic [30:0]        inv_dx_sq;
    logic [30:0]        inv_dy_sq;
    logic [30:0]        inv_dz_sq;
    logic [30:0]        time_step;
    logic signed [31:0] linear_gain;
    logic signed [31:0] bias;
  } cfg_t;

  typedef struct packed {
    logic        last;
    logic [5:0]  x;
    logic [5:0]  y;
    logic [15:0] z;
  } side_t;

  typedef struct packed {
    logic  emit;
    side_t side;
    slot_t cs;
    slot_t ls;
  } scan_t;

  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] xm;
    logic signed [31:0] xp;
    logic signed [31:0] ym;
    logic signed [31:0] yp;
    logic signed [31:0] zm;
    logic signed [31:0] v;
  } ops_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor(p / 2^16), clamped
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    return sat32(p >>> 16);
  endfunction

  function automatic logic [31:0] sel3(input slot_t s, input logic [31:0] a0,
                                       input logic [31:0] a1, input logic [31:0] a2);
    logic [31:0] r;
    case (s)
      2'd0:    r = a0;
      2'd1:    r = a1;
      default: r = a2;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/reaction_diffusion_stencil_3d.sv =====
// ----------------------------------------------------------------------------
// reaction_diffusion_stencil_3d: streaming 3-D reaction-diffusion update
// Voxels enter one per beat in raster order (x fastest, then y, then plane),
// a leading ghost plane, the slab planes, then a trailing ghost plane. The
// block takes one voxel per cycle unless stalled; each beat of plane z+1
// returns the updated voxel of plane z via read stage, six arithmetic stages
// and output register. Throughput is set by the plane stores: the last three
// planes live in three slots, each kept as three copies of a two-read-port
// RAM so that all six stencil reads issue in the same cycle as the write,
// 9*PLANE_WIDTH*PLANE_HEIGHT words in all. The stores need no clearing pass
// after reset; the first two planes fill them before any result is formed.
// Configuration writes are applied at once and belong to idle periods.
// ----------------------------------------------------------------------------
module reaction_diffusion_stencil_3d #(
  parameter int PLANE_WIDTH  = rds_pkg::RDS_PLANE_WIDTH,
  parameter int PLANE_HEIGHT = rds_pkg::RDS_PLANE_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rds_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rds_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         voxel_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         new_value,
  output logic [5:0]                 out_x,
  output logic [5:0]                 out_y,
  output logic [15:0]                out_z,
  output logic                       last
);
  import rds_pkg::*;

  localparam int DEPTH = PLANE_WIDTH * PLANE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NSLOT = 3;
  localparam int NCOPY = 3;

  cfg_t        cfg;
  logic [15:0] slab_planes;

  logic          accept;
  logic          advance;
  logic          load_out;
  scan_t         meta;
  slot_t         wslot;
  logic [AW-1:0] addr_c, addr_xm, addr_xp, addr_ym, addr_yp;
  logic [AW-1:0] ra_a [NCOPY];
  logic [AW-1:0] ra_b [NCOPY];
  logic [31:0]   rda [NSLOT][NCOPY];
  logic [31:0]   rdb [NSLOT][NCOPY];

  logic               rd_valid;
  scan_t              rd_meta;
  logic signed [31:0] rd_v;
  ops_t               ops;

  logic               res_valid;
  logic signed [31:0] res_value;
  side_t              res_side;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_dx_sq   <= RST_INV_SQ;
      cfg.inv_dy_sq   <= RST_INV_SQ;
      cfg.inv_dz_sq   <= RST_INV_SQ;
      cfg.time_step   <= RST_TIME_STEP;
      cfg.linear_gain <= RST_LINEAR_GAIN;
      cfg.bias        <= RST_BIAS;
      slab_planes     <= RST_SLAB_PLANES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_DX_SQ:   cfg.inv_dx_sq   <= cfg_data[30:0];
        REG_INV_DY_SQ:   cfg.inv_dy_sq   <= cfg_data[30:0];
        REG_INV_DZ_SQ:   cfg.inv_dz_sq   <= cfg_data[30:0];
        REG_TIME_STEP:   cfg.time_step   <= cfg_data[30:0];
        REG_LINEAR_GAIN: cfg.linear_gain <= $signed(cfg_data);
        REG_BIAS:        cfg.bias        <= $signed(cfg_data);
        REG_SLAB_PLANES: slab_planes     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // flow control: the pipe moves unless a full last stage faces a held result
  assign load_out = !out_valid || out_ready;
  assign advance  = load_out || !res_valid;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  rds_scan #(
    .PLANE_WIDTH (PLANE_WIDTH),
    .PLANE_HEIGHT(PLANE_HEIGHT),
    .AW          (AW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .slab_planes(slab_planes),
    .meta       (meta),
    .wslot      (wslot),
    .addr_c     (addr_c),
    .addr_xm    (addr_xm),
    .addr_xp    (addr_xp),
    .addr_ym    (addr_ym),
    .addr_yp    (addr_yp)
  );

  assign ra_a[0] = addr_c;
  assign ra_b[0] = addr_xm;
  assign ra_a[1] = addr_xp;
  assign ra_b[1] = addr_ym;
  assign ra_a[2] = addr_yp;
  assign ra_b[2] = addr_c;

  for (genvar s = 0; s < NSLOT; s++) begin : g_slot
    for (genvar c = 0; c < NCOPY; c++) begin : g_copy
      rds_ram #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (32)
      ) u_ram (
        .clk    (clk),
        .we     (accept && (wslot == slot_t'(s))),
        .waddr  (addr_c),
        .wdata  (voxel_value),
        .re     (advance),
        .raddr_a(ra_a[c]),
        .raddr_b(ra_b[c]),
        .rdata_a(rda[s][c]),
        .rdata_b(rdb[s][c])
      );
    end
  end

  // read stage, alongside the registered RAM outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (advance) begin
      rd_valid <= accept && meta.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_meta <= meta;
      rd_v    <= voxel_value;
    end
  end

  always_comb begin
    ops.u  = sel3(rd_meta.cs, rda[0][0], rda[1][0], rda[2][0]);
    ops.xm = sel3(rd_meta.cs, rdb[0][0], rdb[1][0], rdb[2][0]);
    ops.xp = sel3(rd_meta.cs, rda[0][1], rda[1][1], rda[2][1]);
    ops.ym = sel3(rd_meta.cs, rdb[0][1], rdb[1][1], rdb[2][1]);
    ops.yp = sel3(rd_meta.cs, rda[0][2], rda[1][2], rda[2][2]);
    ops.zm = sel3(rd_meta.ls, rdb[0][2], rdb[1][2], rdb[2][2]);
    ops.v  = rd_v;
  end

  rds_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (rd_valid),
    .ops      (ops),
    .in_side  (rd_meta.side),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res_value(res_value),
    .res_side (res_side)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && res_valid) begin
      new_value <= res_value;
      out_x     <= res_side.x;
      out_y     <= res_side.y;
      out_z     <= res_side.z;
      last      <= res_side.last;
    end
  end

  a_slot_apart: assert property (@(posedge clk) disable iff (rst)
    accept |-> (wslot != meta.cs) && (wslot != meta.ls) && (meta.cs != meta.ls))
    else $error("write slot collides with a stencil read slot");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result beat dropped without being taken");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid && !out_ready) |=> res_valid && out_valid)
    else $error("stalled pipeline lost its last stage");

endmodule

// ===== hdl/rds_ram.sv =====
// ----------------------------------------------------------------------------
// rds_ram: plane store bank
// One write port, two read ports with registered read data and read enable.
// ----------------------------------------------------------------------------
module rds_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hdl/rds_scan.sv =====
// ----------------------------------------------------------------------------
// rds_scan: raster position tracker
// Keeps x, y, stream plane and store slot, and forms the store addresses of
// the center voxel and its four in-plane neighbors with periodic wrap.
// ----------------------------------------------------------------------------
module rds_scan #(
  parameter int PLANE_WIDTH  = 64,
  parameter int PLANE_HEIGHT = 64,
  parameter int AW           = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [15:0]          slab_planes,
  output rds_pkg::scan_t       meta,
  output rds_pkg::slot_t       wslot,
  output logic [AW-1:0]        addr_c,
  output logic [AW-1:0]        addr_xm,
  output logic [AW-1:0]        addr_xp,
  output logic [AW-1:0]        addr_ym,
  output logic [AW-1:0]        addr_yp
);
  import rds_pkg::*;

  localparam int XW = $clog2(PLANE_WIDTH);
  localparam int YW = $clog2(PLANE_HEIGHT);
  localparam int XE = (XW > 6) ? XW : 6;
  localparam int YE = (YW > 6) ? YW : 6;
  localparam logic [AW-1:0] ROW_STEP  = AW'(PLANE_WIDTH);
  localparam logic [AW-1:0] ROW_WRAP  = AW'(PLANE_WIDTH - 1);
  localparam logic [AW-1:0] COL_WRAP  = AW'((PLANE_HEIGHT - 1) * PLANE_WIDTH);
  localparam logic [XW-1:0] X_END     = XW'(PLANE_WIDTH - 1);
  localparam logic [YW-1:0] Y_END     = YW'(PLANE_HEIGHT - 1);

  logic [XW-1:0] x, x_next;
  logic [YW-1:0] y, y_next;
  logic [16:0]   z, z_next;
  slot_t         slot, slot_next;
  logic [AW-1:0] addr, addr_next;

  logic          x_last;
  logic          y_last;
  logic [16:0]   end_plane;
  logic [XE-1:0] x_ext;
  logic [YE-1:0] y_ext;

  assign x_last    = (x == X_END);
  assign y_last    = (y == Y_END);
  assign end_plane = {1'b0, slab_planes} + 17'd1;
  assign x_ext     = XE'(x);
  assign y_ext     = YE'(y);

  always_comb begin
    x_next    = x + XW'(1);
    y_next    = y;
    z_next    = z;
    slot_next = slot;
    addr_next = addr + AW'(1);
    if (x_last) begin
      x_next = '0;
      y_next = y + YW'(1);
      if (y_last) begin
        y_next    = '0;
        addr_next = '0;
        if (z >= end_plane) begin
          z_next    = '0;
          slot_next = 2'd0;
        end else begin
          z_next    = z + 17'd1;
          slot_next = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x    <= '0;
      y    <= '0;
      z    <= '0;
      slot <= 2'd0;
      addr <= '0;
    end else if (step) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      slot <= slot_next;
      addr <= addr_next;
    end
  end

  assign wslot   = slot;
  assign addr_c  = addr;
  assign addr_xm = (x == '0) ? addr + ROW_WRAP : addr - AW'(1);
  assign addr_xp = x_last ? addr - ROW_WRAP : addr + AW'(1);
  assign addr_ym = (y == '0) ? addr + COL_WRAP : addr - ROW_STEP;
  assign addr_yp = y_last ? addr - COL_WRAP : addr + ROW_STEP;

  always_comb begin
    meta.emit      = (z >= 17'd2) && (z <= end_plane);
    meta.side.last = x_last && y_last && (z == end_plane);
    meta.side.x    = x_ext[5:0];
    meta.side.y    = y_ext[5:0];
    meta.side.z    = z[15:0] - 16'd2;
    meta.cs        = (slot == 2'd0) ? 2'd2 : slot - 2'd1;
    meta.ls        = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
  end

  a_plane_start_slot: assert property (@(posedge clk) disable iff (rst)
    (z == 17'd0) |-> (slot == 2'd0))
    else $error("store slot not reset at slab start");

  a_linear_addr: assert property (@(posedge clk) disable iff (rst)
    addr == AW'(int'(y) * PLANE_WIDTH + int'(x)))
    else $error("linear address out of step with x/y");

endmodule

// ===== hdl/rds_arith.sv =====
// ----------------------------------------------------------------------------
// rds_arith: reaction-diffusion update pipeline
// Six register stages: second differences, products, scaling, Laplacian sum
// with cube product, reaction sum, time-step product. Final add is left
// combinational for the output register.
// ----------------------------------------------------------------------------
module rds_arith (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  rds_pkg::ops_t      ops,
  input  rds_pkg::side_t     in_side,
  input  rds_pkg::cfg_t      cfg,
  output logic               res_valid,
  output logic signed [31:0] res_value,
  output rds_pkg::side_t     res_side
);
  import rds_pkg::*;

  logic  a_valid, b_valid, c_valid, d_valid, e_valid, f_valid;
  side_t a_side, b_side, c_side, d_side, e_side, f_side;
  logic signed [31:0] a_u, b_u, c_u, d_u, e_u, f_u;

  logic signed [31:0] a_dx, a_dy, a_dz;
  logic signed [63:0] b_px, b_py, b_pz, b_pm, b_pq;
  logic signed [31:0] c_lx, c_ly, c_lz, c_m, c_q;
  logic signed [31:0] d_lap, d_m;
  logic signed [63:0] d_pc;
  logic signed [31:0] e_r;
  logic signed [63:0] f_pt;

  logic signed [33:0] sum_x, sum_y, sum_z;
  logic signed [34:0] sum_lap, sum_r;
  logic signed [31:0] cube;
  logic signed [31:0] f_t;
  logic signed [33:0] sum_new;

  assign sum_x = 34'(ops.xm) + 34'(ops.xp) - (34'(ops.u) <<< 1);
  assign sum_y = 34'(ops.ym) + 34'(ops.yp) - (34'(ops.u) <<< 1);
  assign sum_z = 34'(ops.zm) + 34'(ops.v)  - (34'(ops.u) <<< 1);

  assign sum_lap = 35'(c_lx) + 35'(c_ly) + 35'(c_lz);
  assign cube    = qsat(d_pc);
  assign sum_r   = 35'(d_lap) + 35'(d_m) - 35'(cube) + 35'(cfg.bias);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_side <= in_side;
      a_u    <= ops.u;
      a_dx   <= sat32(64'(sum_x));
      a_dy   <= sat32(64'(sum_y));
      a_dz   <= sat32(64'(sum_z));

      b_side <= a_side;
      b_u    <= a_u;
      b_px   <= $signed({1'b0, cfg.inv_dx_sq}) * a_dx;
      b_py   <= $signed({1'b0, cfg.inv_dy_sq}) * a_dy;
      b_pz   <= $signed({1'b0, cfg.inv_dz_sq}) * a_dz;
      b_pm   <= cfg.linear_gain * a_u;
      b_pq   <= a_u * a_u;

      c_side <= b_side;
      c_u    <= b_u;
      c_lx   <= qsat(b_px);
      c_ly   <= qsat(b_py);
      c_lz   <= qsat(b_pz);
      c_m    <= qsat(b_pm);
      c_q    <= qsat(b_pq);

      d_side <= c_side;
      d_u    <= c_u;
      d_lap  <= sat32(64'(sum_lap));
      d_m    <= c_m;
      d_pc   <= c_q * c_u;

      e_side <= d_side;
      e_u    <= d_u;
      e_r    <= sat32(64'(sum_r));

      f_side <= e_side;
      f_u    <= e_u;
      f_pt   <= $signed({1'b0, cfg.time_step}) * e_r;
    end
  end

  assign f_t     = qsat(f_pt);
  assign sum_new = 34'(f_u) + 34'(f_t);

  assign res_valid = f_valid;
  assign res_value = sat32(64'(sum_new));
  assign res_side  = f_side;

endmodule

// ===== sim/tb_reaction_diffusion_stencil_3d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reaction_diffusion_stencil_3d: stream test of the 3-D stencil update
// Voxel slabs go in through the valid/ready input with random gaps. A
// behavioral predictor keeps its own plane stores and registers and queues
// the updated voxel that each beat should produce. Every output beat is
// checked field by field against the oldest queued update. Tests cover reset
// coefficients, extreme settings, ghost-only slabs, a slab length cut short
// mid-stream and randomly configured slabs.
// ----------------------------------------------------------------------------
module tb_reaction_diffusion_stencil_3d;
  import rds_pkg::*;

  localparam int PW             = RDS_PLANE_WIDTH;
  localparam int PH             = RDS_PLANE_HEIGHT;
  localparam int PLANE_WORDS    = PW * PH;
  localparam int LATENCY_WAIT   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 200;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef enum int {MIX_SMALL, MIX_EXTREME, MIX_BLEND} value_mix_e;

  typedef struct {
    logic signed [31:0] value;
    logic [5:0]         x;
    logic [5:0]         y;
    logic [15:0]        z;
    logic               fin;
  } voxel_update_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IW-1:0]        cfg_index = '0;
  logic [CFG_DW-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [31:0]       voxel_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [31:0]       new_value;
  logic [5:0]               out_x;
  logic [5:0]               out_y;
  logic [15:0]              out_z;
  logic                     last;

  always #5 clk = ~clk;

  reaction_diffusion_stencil_3d u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .voxel_value (voxel_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .new_value   (new_value),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .last        (last)
  );

  logic signed [31:0] plane_mem [0:2][0:PLANE_WORDS-1];
  int unsigned        scan_x = 0;
  int unsigned        scan_y = 0;
  int unsigned        scan_z = 0;
  longint             coef_dx = 65536;
  longint             coef_dy = 65536;
  longint             coef_dz = 65536;
  longint             dt_step = 6554;
  longint             gain = -65536;
  longint             offset = 0;
  int unsigned        slab_planes = 32;
  voxel_update_t      expected_updates[$];
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  bit                 in_stalled = 1'b0;
  bit                 out_stalled = 1'b0;

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // floor(a*b / 2^16), clamped
  function automatic longint qprod(longint a, longint b);
    return clamp_q((a * b) >>> 16);
  endfunction

  function automatic longint store_word(int unsigned slot, int unsigned x, int unsigned y);
    return longint'(plane_mem[slot][y * PW + x]);
  endfunction

  task automatic predict_update(logic signed [31:0] v);
    int unsigned   end_plane, cs, ls, xm, xp, ym, yp;
    longint        u, lap, cube, react, next_val;
    voxel_update_t upd;
    end_plane = slab_planes + 1;
    plane_mem[scan_z % 3][scan_y * PW + scan_x] = v;
    if (scan_z >= 2 && scan_z <= end_plane) begin
      cs = (scan_z + 2) % 3;
      ls = (scan_z + 1) % 3;
      xm = (scan_x == 0) ? PW - 1 : scan_x - 1;
      xp = (scan_x == PW - 1) ? 0 : scan_x + 1;
      ym = (scan_y == 0) ? PH - 1 : scan_y - 1;
      yp = (scan_y == PH - 1) ? 0 : scan_y + 1;
      u = store_word(cs, scan_x, scan_y);
      lap = clamp_q(
        qprod(coef_dx, clamp_q(store_word(cs, xm, scan_y) + store_word(cs, xp, scan_y) - 2 * u)) +
        qprod(coef_dy, clamp_q(store_word(cs, scan_x, ym) + store_word(cs, scan_x, yp) - 2 * u)) +
        qprod(coef_dz, clamp_q(store_word(ls, scan_x, scan_y) + longint'(v) - 2 * u)));
      cube = qprod(qprod(u, u), u);
      react = clamp_q(lap + qprod(gain, u) - cube + offset);
      next_val = clamp_q(u + qprod(dt_step, react));
      upd.value = next_val[31:0];
      upd.x = scan_x[5:0];
      upd.y = scan_y[5:0];
      upd.z = 16'(scan_z - 2);
      upd.fin = (scan_x == PW - 1) && (scan_y == PH - 1) && (scan_z == end_plane);
      expected_updates.push_back(upd);
    end
    scan_x++;
    if (scan_x == PW) begin
      scan_x = 0;
      scan_y++;
      if (scan_y == PH) begin
        scan_y = 0;
        scan_z = (scan_z >= end_plane) ? 0 : scan_z + 1;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch: %s", msg);
  endtask

  function automatic int draw_gap(inout bit stalled);
    if ($urandom_range(0, 31) == 0) stalled = ($urandom_range(0, 3) == 0);
    return stalled ? $urandom_range(0, 19) : 0;
  endfunction

  function automatic logic signed [31:0] draw_voxel(value_mix_e mix);
    int pick;
    pick = (mix == MIX_SMALL) ? 0 : (mix == MIX_EXTREME) ? 9 : $urandom_range(0, 9);
    if (pick <= 5) return $signed(32'($urandom_range(0, 262143))) - 32'sd131072;
    if (pick <= 7) return $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return 32'sd1;
      4:       return -32'sd1;
      5:       return 32'sd65536;
      6:       return -32'sd65536;
      default: return 32'sh7ffffffe;
    endcase
  endfunction

  function automatic logic [30:0] rand_coef();
    case ($urandom_range(0, 4))
      0:       return 31'($urandom_range(0, 262144));
      1:       return 31'($urandom_range(0, 65536));
      2:       return 31'($urandom);
      3:       return 31'd0;
      default: return 31'h7fffffff;
    endcase
  endfunction

  function automatic logic [31:0] rand_signed();
    case ($urandom_range(0, 4))
      0:       return 32'($signed(32'($urandom_range(0, 262143))) - 32'sd131072);
      1:       return $urandom;
      2:       return 32'h7fffffff;
      3:       return 32'h80000000;
      default: return 32'h0;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] index, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_INV_DX_SQ:   coef_dx = longint'(data[30:0]);
      REG_INV_DY_SQ:   coef_dy = longint'(data[30:0]);
      REG_INV_DZ_SQ:   coef_dz = longint'(data[30:0]);
      REG_TIME_STEP:   dt_step = longint'(data[30:0]);
      REG_LINEAR_GAIN: gain = longint'($signed(data));
      REG_BIAS:        offset = longint'($signed(data));
      REG_SLAB_PLANES: slab_planes = data[15:0];
      default: ;
    endcase
  endtask

  // bit 31 of the unsigned registers is unused and gets random content
  task automatic write_coefficients(logic [30:0] dx, logic [30:0] dy, logic [30:0] dz,
                                    logic [30:0] dt, logic [31:0] mu, logic [31:0] a);
    write_reg(REG_INV_DX_SQ, {1'($urandom_range(0, 1)), dx});
    write_reg(REG_INV_DY_SQ, {1'($urandom_range(0, 1)), dy});
    write_reg(REG_INV_DZ_SQ, {1'($urandom_range(0, 1)), dz});
    write_reg(REG_TIME_STEP, {1'($urandom_range(0, 1)), dt});
    write_reg(REG_LINEAR_GAIN, mu);
    write_reg(REG_BIAS, a);
  endtask

  task automatic write_slab_planes(logic [15:0] n);
    logic [31:0] spare;
    spare = $urandom;
    write_reg(REG_SLAB_PLANES, {spare[31:16], n});
  endtask

  task automatic send_voxel(logic signed [31:0] v);
    int gap;
    gap = draw_gap(in_stalled);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    voxel_value <= v;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_update(v);
  endtask

  task automatic drain_updates();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic run_planes(int planes, value_mix_e mix, int pause_at);
    for (int i = 0; i < planes * PLANE_WORDS; i++) begin
      if (i == pause_at) drain_updates();
      send_voxel(draw_voxel(mix));
    end
  endtask

  task automatic check_update();
    voxel_update_t want;
    if (expected_updates.size() == 0) begin
      report_mismatch($sformatf("unexpected beat x=%0d y=%0d z=%0d value=%h",
                                out_x, out_y, out_z, new_value));
      return;
    end
    want = expected_updates.pop_front();
    if (new_value !== want.value)
      report_mismatch($sformatf("new_value at (%0d,%0d,%0d): got %h want %h",
                                want.x, want.y, want.z, new_value, want.value));
    if (out_x !== want.x)
      report_mismatch($sformatf("out_x: got %0d want %0d", out_x, want.x));
    if (out_y !== want.y)
      report_mismatch($sformatf("out_y: got %0d want %0d", out_y, want.y));
    if (out_z !== want.z)
      report_mismatch($sformatf("out_z: got %0d want %0d", out_z, want.z));
    if (last !== want.fin)
      report_mismatch($sformatf("last at (%0d,%0d,%0d): got %b want %b",
                                want.x, want.y, want.z, last, want.fin));
  endtask

  initial begin
    int gap;
    wait (rst === 1'b0);
    forever begin
      gap = draw_gap(out_stalled);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_update();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("reaction_diffusion_stencil_3d verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_default_coefficients();
    write_slab_planes(16'd1);
    write_reg(REG_UNUSED, $urandom);
    run_planes(3, MIX_SMALL, -1);
    drain_updates();
  endtask

  task automatic test_extreme_settings();
    write_coefficients(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                       32'h7fffffff, 32'h7fffffff);
    run_planes(3, MIX_EXTREME, -1);
    drain_updates();
    write_coefficients(31'd0, 31'd0, 31'd0, 31'h7fffffff, 32'h80000000, 32'h80000000);
    run_planes(3, MIX_EXTREME, -1);
    drain_updates();
    write_coefficients(31'd65536, 31'd65536, 31'd65536, 31'd0, 32'h0, 32'h0);
    run_planes(3, MIX_BLEND, -1);
    drain_updates();
  endtask

  // two ghost planes only: nothing comes out
  task automatic test_ghost_only_slab();
    write_coefficients(31'd65536, 31'd32768, 31'd131072, 31'd6554, 32'hffff0000, 32'h00008000);
    write_slab_planes(16'd0);
    run_planes(2, MIX_BLEND, -1);
    drain_updates();
  endtask

  // long slab cut to one plane after its first two slab planes; the next plane
  // lies past the end and must wrap to a fresh slab
  task automatic test_slab_resize();
    write_slab_planes(16'hffff);
    run_planes(3, MIX_BLEND, -1);
    drain_updates();
    write_slab_planes(16'd1);
    run_planes(4, MIX_SMALL, -1);
    drain_updates();
  endtask

  task automatic test_random_slabs();
    int planes;
    for (int s = 0; s < 2; s++) begin
      write_coefficients(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                         rand_signed(), rand_signed());
      planes = $urandom_range(1, 2);
      write_slab_planes(16'(planes));
      run_planes(planes + 2, MIX_BLEND, $urandom_range(1, (planes + 2) * PLANE_WORDS - 1));
      drain_updates();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_coefficients();
    test_extreme_settings();
    test_ghost_only_slab();
    test_slab_resize();
    test_random_slabs();
    drain_updates();
    if (mismatch_count == 0) begin
      $display("reaction_diffusion_stencil_3d verification clean");
    end else begin
      $display("reaction_diffusion_stencil_3d verification failed");
    end
    $finish;
  end

endmodule
